// ===== rtl/dba_pkg.sv =====
// dba_pkg: shared widths, codes, payload structs and controller/datapath
// command and status bundles for the disk block allocator.
// No dependencies.
package dba_pkg;

   localparam int SIZE_W    = 19;
   localparam int BS_W      = 13;
   localparam int DB_W      = 11;
   localparam int IDX_W     = 10;
   localparam int ST_W      = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 13;

   // map memory row: 16 blocks per word
   localparam int ROW_W  = 16;
   localparam int ROW_SH = 4;

   localparam int DISK_BLOCKS_DEF    = 1024;
   localparam int MAX_RUN_DEF        = 64;
   localparam int MAX_BLOCK_SIZE_DEF = 4096;

   localparam logic [BS_W-1:0] BLOCK_SIZE_RST  = 13'd512;
   localparam logic [DB_W-1:0] DISK_BLOCKS_RST = 11'd1024;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISK_BLOCKS = 1'd1;

   localparam logic [ST_W-1:0] ST_OK      = 3'd0;
   localparam logic [ST_W-1:0] ST_ZERO    = 3'd1;
   localparam logic [ST_W-1:0] ST_NOSPACE = 3'd2;
   localparam logic [ST_W-1:0] ST_TOOLONG = 3'd3;
   localparam logic [ST_W-1:0] ST_BADFREE = 3'd4;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef struct packed {
      logic              action;
      logic [SIZE_W-1:0] size_bytes;
      logic [IDX_W-1:0]  block_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] out_block;
      logic [BS_W-1:0]  bytes_used;
      logic [ST_W-1:0]  status;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic            cap_req;
      logic            div_start;
      logic            ptr_clr;
      logic            ptr_inc;
      logic            ptr_load_idx;
      logic            mem_clear;
      logic            row_load;
      logic            row_wb;
      logic            alloc_bit;
      logic            free_do;
      logic            emit_err;
      logic [ST_W-1:0] err_code;
      logic            rc_clr;
      logic            rc_add;
      logic            rc_done;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic size_zero;
      logic idx_out;
      logic div_done;
      logic too_long;
      logic no_space;
      logic blk_used;
      logic row_has_free;
      logic need_met;
      logic ptr_last;
      logic out_ready;
   } stat_type;

endpackage

// ===== rtl/dba_div.sv =====
// dba_div: restoring divider, one quotient bit per cycle.
// Splits a byte count into whole blocks and remainder. Uses dba_pkg.
module dba_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [dba_pkg::SIZE_W-1:0]  dividend,
   input  logic [dba_pkg::BS_W-1:0]    divisor,
   output logic                        done,
   output logic [dba_pkg::SIZE_W-1:0]  quot,
   output logic [dba_pkg::BS_W-1:0]    rem
);

   localparam int CNT_W = $clog2(dba_pkg::SIZE_W + 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [dba_pkg::SIZE_W-1:0] quo_ff, quo_in;
   logic [dba_pkg::BS_W-1:0]   rem_ff, rem_in;
   logic [dba_pkg::BS_W-1:0]   den_ff, den_in;
   logic [dba_pkg::BS_W:0]     trial;
   logic                       ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[dba_pkg::SIZE_W-1]};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(dba_pkg::SIZE_W);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? dba_pkg::BS_W'(trial - {1'b0, den_ff})
                     : dba_pkg::BS_W'(trial);
         quo_in = {quo_ff[dba_pkg::SIZE_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

endmodule

// ===== rtl/dba_datapath.sv =====
// dba_datapath: block map memory, row scan, free counter, divider and
// result register. Driven by dba_ctrl commands. Uses dba_pkg, dba_div.
module dba_datapath #(
   parameter int DISK_BLOCKS    = dba_pkg::DISK_BLOCKS_DEF,
   parameter int MAX_RUN        = dba_pkg::MAX_RUN_DEF,
   parameter int MAX_BLOCK_SIZE = dba_pkg::MAX_BLOCK_SIZE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dba_pkg::cmd_type          cmd,
   output dba_pkg::stat_type         stat,
   input  dba_pkg::req_type          req_data,
   input  logic [dba_pkg::BS_W-1:0]  block_size,
   input  logic [dba_pkg::DB_W-1:0]  disk_blocks,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output dba_pkg::rsp_type          rsp_data
);

   localparam int ROWS   = (DISK_BLOCKS + dba_pkg::ROW_W - 1) / dba_pkg::ROW_W;
   localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int NB_W   = $clog2(DISK_BLOCKS + 1);
   localparam int RUN_W  = $clog2(MAX_RUN + 1);
   localparam int NEED_W = dba_pkg::SIZE_W + 1;
   localparam int PC_W   = dba_pkg::ROW_SH + 1;

   logic [dba_pkg::ROW_W-1:0] map_mem [ROWS];
   logic [dba_pkg::ROW_W-1:0] rdata_ff;
   logic                      mem_we;
   logic [dba_pkg::ROW_W-1:0] mem_wdata;

   dba_pkg::req_type          req_ff, req_in;
   logic [ROW_AW-1:0]         row_ptr_ff, row_ptr_in;
   logic [dba_pkg::ROW_W-1:0] work_row_ff, work_row_in;
   logic [RUN_W-1:0]          got_ff, got_in;
   logic [NB_W-1:0]           free_count_ff, free_count_in;
   logic [NB_W-1:0]           acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   dba_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic [dba_pkg::BS_W-1:0]    bs_eff;
   logic [NB_W-1:0]             n_eff;
   logic                        div_done;
   logic [dba_pkg::SIZE_W-1:0]  quot;
   logic [dba_pkg::BS_W-1:0]    rem;
   logic [NEED_W-1:0]           need;
   logic [dba_pkg::ROW_SH-1:0]  bit_pos;
   logic [dba_pkg::ROW_SH-1:0]  idx_bit;
   logic [ROW_AW-1:0]           idx_row;
   logic [PC_W-1:0]             pc;
   logic [NB_W-1:0]             acc_sum;
   logic                        fin;
   logic                        out_ready;
   logic                        ptr_last;
   logic                        row_has_free;
   logic [dba_pkg::ROW_W-1:0]   free_bits;

   always_comb begin
      if (block_size == '0) begin
         bs_eff = dba_pkg::BS_W'(1);
      end else if (32'(block_size) > MAX_BLOCK_SIZE) begin
         bs_eff = dba_pkg::BS_W'(MAX_BLOCK_SIZE);
      end else begin
         bs_eff = block_size;
      end
      if (32'(disk_blocks) > DISK_BLOCKS) begin
         n_eff = NB_W'(DISK_BLOCKS);
      end else begin
         n_eff = NB_W'(disk_blocks);
      end
   end

   dba_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (req_ff.size_bytes),
      .divisor  (bs_eff),
      .done     (div_done),
      .quot     (quot),
      .rem      (rem)
   );

   assign need     = NEED_W'(quot) + NEED_W'(rem != '0);
   assign idx_bit  = req_ff.block_index[dba_pkg::ROW_SH-1:0];
   assign idx_row  = ROW_AW'(32'(req_ff.block_index) >> dba_pkg::ROW_SH);
   assign ptr_last = row_ptr_ff == ROW_AW'(ROWS - 1);
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign fin      = (32'(got_ff) + 32'd1) == 32'(need);
   assign free_bits = ~work_row_ff;
   assign row_has_free = |free_bits;

   // lowest free block in the working row
   always_comb begin
      bit_pos = '0;
      for (int b = dba_pkg::ROW_W - 1; b >= 0; b--) begin
         if (free_bits[b]) bit_pos = dba_pkg::ROW_SH'(b);
      end
   end

   // free blocks in the row just read, limited to the disk size
   always_comb begin
      pc = '0;
      for (int b = 0; b < dba_pkg::ROW_W; b++) begin
         if (!rdata_ff[b] &&
             (((32'(row_ptr_ff) << dba_pkg::ROW_SH) + 32'(b)) < 32'(n_eff))) begin
            pc = pc + PC_W'(1);
         end
      end
      acc_sum = acc_ff + NB_W'(pc);
   end

   always_comb begin
      mem_we = cmd.mem_clear || cmd.row_wb || cmd.free_do;
      if (cmd.mem_clear) begin
         mem_wdata = '0;
      end else if (cmd.free_do) begin
         mem_wdata = rdata_ff & ~(dba_pkg::ROW_W'(1) << idx_bit);
      end else begin
         mem_wdata = work_row_ff;
      end
   end

   always_comb begin
      req_in        = cmd.cap_req ? req_data : req_ff;
      row_ptr_in    = row_ptr_ff;
      work_row_in   = work_row_ff;
      got_in        = got_ff;
      free_count_in = free_count_ff;
      acc_in        = acc_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.ptr_clr) begin
         row_ptr_in = '0;
         got_in     = '0;
      end else if (cmd.ptr_inc) begin
         row_ptr_in = row_ptr_ff + ROW_AW'(1);
      end else if (cmd.ptr_load_idx) begin
         row_ptr_in = idx_row;
      end

      if (cmd.rc_clr) acc_in = '0;
      if (cmd.rc_add) acc_in = acc_sum;
      if (cmd.rc_done) free_count_in = acc_sum;

      if (cmd.row_load) work_row_in = rdata_ff;

      if (cmd.alloc_bit) begin
         work_row_in   = work_row_ff | (dba_pkg::ROW_W'(1) << bit_pos);
         got_in        = got_ff + RUN_W'(1);
         free_count_in = free_count_ff - NB_W'(1);
         rsp_valid_in  = 1'b1;
         rsp_data_in.out_block  = dba_pkg::IDX_W'(
            (32'(row_ptr_ff) << dba_pkg::ROW_SH) | 32'(bit_pos));
         rsp_data_in.bytes_used = (fin && rem != '0) ? rem : bs_eff;
         rsp_data_in.status     = dba_pkg::ST_OK;
         rsp_data_in.last       = fin;
      end else if (cmd.free_do) begin
         free_count_in = free_count_ff + NB_W'(1);
         rsp_valid_in  = 1'b1;
         rsp_data_in.out_block  = req_ff.block_index;
         rsp_data_in.bytes_used = '0;
         rsp_data_in.status     = dba_pkg::ST_OK;
         rsp_data_in.last       = 1'b1;
      end else if (cmd.emit_err) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.out_block  = (cmd.err_code == dba_pkg::ST_BADFREE) ?
                                  req_ff.block_index : '0;
         rsp_data_in.bytes_used = '0;
         rsp_data_in.status     = cmd.err_code;
         rsp_data_in.last       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= map_mem[row_ptr_ff];
      if (mem_we) begin
         map_mem[row_ptr_ff] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ptr_ff    <= '0;
         got_ff        <= '0;
         free_count_ff <= '0;
         acc_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         row_ptr_ff    <= row_ptr_in;
         got_ff        <= got_in;
         free_count_ff <= free_count_in;
         acc_ff        <= acc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff      <= req_in;
      work_row_ff <= work_row_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      stat.is_free      = req_ff.action == dba_pkg::ACT_FREE;
      stat.size_zero    = req_ff.size_bytes == '0;
      stat.idx_out      = 32'(req_ff.block_index) >= 32'(n_eff);
      stat.div_done     = div_done;
      stat.too_long     = 32'(need) > MAX_RUN;
      stat.no_space     = 32'(need) > 32'(free_count_ff);
      stat.blk_used     = rdata_ff[idx_bit];
      stat.row_has_free = row_has_free;
      stat.need_met     = 32'(got_ff) == 32'(need);
      stat.ptr_last     = ptr_last;
      stat.out_ready    = out_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.alloc_bit, cmd.free_do, cmd.emit_err}))
      else $error("more than one result source in a cycle");

   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc_bit || cmd.free_do || cmd.emit_err) |-> out_ready)
      else $error("result written over a beat still waiting");

   a_ptr_wrap: assert property (@(posedge clock) disable iff (reset)
      cmd.ptr_inc |-> !ptr_last)
      else $error("row pointer stepped past the last map row");

   a_alloc_free: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_bit |-> row_has_free)
      else $error("allocation from a row with no free block");
`endif

endmodule

// ===== rtl/dba_ctrl.sv =====
// dba_ctrl: sequencer for map clear, free recount, allocate and free.
// Issues dba_pkg::cmd_type to dba_datapath, reads dba_pkg::stat_type.
module dba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               csr_db_wr,
   output logic               csr_ready,
   input  dba_pkg::stat_type  stat,
   output dba_pkg::cmd_type   cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_RC_READ,
      S_RC_ADD,
      S_IDLE,
      S_DECODE,
      S_DIV,
      S_CHECK,
      S_AL_READ,
      S_AL_LOAD,
      S_AL_SCAN,
      S_FR_READ,
      S_FR_CHECK,
      S_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [dba_pkg::ST_W-1:0]   err_ff, err_in;
   logic                       rc_pend_ff, rc_pend_in;

   always_comb begin
      state_in     = state_ff;
      err_in       = err_ff;
      rc_pend_in   = rc_pend_ff;
      cmd          = '0;
      cmd.err_code = err_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.mem_clear = 1'b1;
            if (stat.ptr_last) begin
               cmd.ptr_clr = 1'b1;
               cmd.rc_clr  = 1'b1;
               rc_pend_in  = 1'b0;
               state_in    = S_RC_READ;
            end else begin
               cmd.ptr_inc = 1'b1;
            end
         end
         S_RC_READ: state_in = S_RC_ADD;
         S_RC_ADD: begin
            cmd.rc_add = 1'b1;
            if (stat.ptr_last) begin
               cmd.rc_done = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.ptr_inc = 1'b1;
               state_in    = S_RC_READ;
            end
         end
         S_IDLE: begin
            if (rc_pend_ff) begin
               cmd.ptr_clr = 1'b1;
               cmd.rc_clr  = 1'b1;
               rc_pend_in  = 1'b0;
               state_in    = S_RC_READ;
            end else if (req_valid) begin
               cmd.cap_req = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.is_free) begin
               if (stat.idx_out) begin
                  err_in   = dba_pkg::ST_BADFREE;
                  state_in = S_EMIT;
               end else begin
                  cmd.ptr_load_idx = 1'b1;
                  state_in         = S_FR_READ;
               end
            end else if (stat.size_zero) begin
               err_in   = dba_pkg::ST_ZERO;
               state_in = S_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (stat.div_done) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat.too_long) begin
               err_in   = dba_pkg::ST_TOOLONG;
               state_in = S_EMIT;
            end else if (stat.no_space) begin
               err_in   = dba_pkg::ST_NOSPACE;
               state_in = S_EMIT;
            end else begin
               cmd.ptr_clr = 1'b1;
               state_in    = S_AL_READ;
            end
         end
         S_AL_READ: state_in = S_AL_LOAD;
         S_AL_LOAD: begin
            cmd.row_load = 1'b1;
            state_in     = S_AL_SCAN;
         end
         S_AL_SCAN: begin
            if (stat.need_met) begin
               cmd.row_wb = 1'b1;
               state_in   = S_IDLE;
            end else if (stat.row_has_free) begin
               if (stat.out_ready) cmd.alloc_bit = 1'b1;
            end else begin
               cmd.row_wb  = 1'b1;
               cmd.ptr_inc = 1'b1;
               state_in    = S_AL_READ;
            end
         end
         S_FR_READ: state_in = S_FR_CHECK;
         S_FR_CHECK: begin
            if (!stat.blk_used) begin
               err_in   = dba_pkg::ST_BADFREE;
               state_in = S_EMIT;
            end else if (stat.out_ready) begin
               cmd.free_do = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_EMIT: begin
            if (stat.out_ready) begin
               cmd.emit_err = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (csr_db_wr) rc_pend_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         err_ff     <= dba_pkg::ST_OK;
         rc_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         err_ff     <= err_in;
         rc_pend_ff <= rc_pend_in;
      end
   end

   assign req_stall = !(state_ff == S_IDLE && !rc_pend_ff);
   assign csr_ready = !(state_ff == S_RC_READ || state_ff == S_RC_ADD);

`ifndef SYNTHESIS
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == S_DECODE)
      else $error("accepted request not decoded");

   a_recount_blocks: assert property (@(posedge clock) disable iff (reset)
      !csr_ready |-> req_stall)
      else $error("request taken during free recount");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |-> state_ff == S_DIV)
      else $error("divider finished outside the divide wait");
`endif

endmodule

// ===== rtl/disk_block_allocator.sv =====
// disk_block_allocator: first-fit block allocator over a used-block bitmap.
// Top level: config registers, dba_ctrl and dba_datapath. Uses dba_pkg.
//
//   port group  dir  handshake          beat
//   req_        in   req_valid/stall    action, size_bytes, block_index
//   rsp_        out  rsp_valid/stall    out_block, bytes_used, status, last
//   csr_        in   csr_valid/ready    csr_index, csr_wdata
//
// Allocate goes through decode, the divide and the check, then per 16-block
// row scanned a read, a load and a scan that grants its free blocks; free
// goes through decode, read and check. One request is in work at a time.
// Reset clears the map one row a cycle, then recounts the free blocks with
// a read and an add step per row; a disk_blocks write also recounts.
// A stalled result holds the scan; the next request is taken while it waits.
module disk_block_allocator #(
   parameter int DISK_BLOCKS    = dba_pkg::DISK_BLOCKS_DEF,
   parameter int MAX_RUN        = dba_pkg::MAX_RUN_DEF,
   parameter int MAX_BLOCK_SIZE = dba_pkg::MAX_BLOCK_SIZE_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  dba_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output dba_pkg::rsp_type                 rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dba_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [dba_pkg::BS_W-1:0] block_size_ff, block_size_in;
   logic [dba_pkg::DB_W-1:0] disk_blocks_ff, disk_blocks_in;
   logic                     csr_wr;
   logic                     csr_db_wr;
   dba_pkg::cmd_type         cmd;
   dba_pkg::stat_type        stat;

   assign csr_wr = csr_valid && csr_ready;

   always_comb begin
      block_size_in  = block_size_ff;
      disk_blocks_in = disk_blocks_ff;
      csr_db_wr      = 1'b0;
      if (csr_wr) begin
         unique case (csr_index)
            dba_pkg::CSR_BLOCK_SIZE: begin
               block_size_in = dba_pkg::BS_W'(csr_wdata);
            end
            dba_pkg::CSR_DISK_BLOCKS: begin
               disk_blocks_in = csr_wdata[dba_pkg::DB_W-1:0];
               csr_db_wr      = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= dba_pkg::BLOCK_SIZE_RST;
         disk_blocks_ff <= dba_pkg::DISK_BLOCKS_RST;
      end else begin
         block_size_ff  <= block_size_in;
         disk_blocks_ff <= disk_blocks_in;
      end
   end

   dba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .csr_db_wr (csr_db_wr),
      .csr_ready (csr_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dba_datapath #(
      .DISK_BLOCKS    (DISK_BLOCKS),
      .MAX_RUN        (MAX_RUN),
      .MAX_BLOCK_SIZE (MAX_BLOCK_SIZE)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_data    (req_data),
      .block_size  (block_size_ff),
      .disk_blocks (disk_blocks_ff),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
